// File: hdl/pofc_pkg.sv
// ---------------------------------------------------------------------------
// PPPoE offer frame checker package
// Shared verdict codes, header constants and discovery tag types.
// ---------------------------------------------------------------------------
package pofc_pkg;

    typedef enum logic [3:0] {
        VERDICT_OK        = 4'd0,
        VERDICT_ETHERTYPE = 4'd1,
        VERDICT_LENGTH    = 4'd2,
        VERDICT_DEST      = 4'd3,
        VERDICT_HOSTUNIQ  = 4'd4,
        VERDICT_CODE      = 4'd5,
        VERDICT_MCAST_SRC = 4'd6,
        VERDICT_ACNAME    = 4'd7,
        VERDICT_SERVICE   = 4'd8,
        VERDICT_ERROR_TAG = 4'd9
    } verdict_t;

    // Configuration register indexes.
    localparam logic REG_OWN_MAC   = 1'b0;
    localparam logic REG_HOST_UNIQ = 1'b1;

    localparam int unsigned HEAD_BYTES = 20;
    localparam int unsigned TAG_SLACK  = 6;

    localparam logic [15:0] ETHERTYPE_DISCOVERY = 16'h8863;
    localparam logic [7:0]  VER_TYPE_1_1        = 8'h11;
    localparam logic [7:0]  CODE_OFFER          = 8'h07;

    localparam logic [15:0] TAG_LIST_END   = 16'h0000;
    localparam logic [15:0] TAG_SVC_NAME   = 16'h0101;
    localparam logic [15:0] TAG_CONC_NAME  = 16'h0102;
    localparam logic [15:0] TAG_UNIQ_ID    = 16'h0103;
    localparam logic [15:0] TAG_SVC_ERROR  = 16'h0201;
    localparam logic [15:0] TAG_AC_ERROR   = 16'h0202;
    localparam logic [15:0] TAG_GEN_ERROR  = 16'h0203;

    localparam logic [15:0] HOST_UNIQ_BYTES = 16'd4;

endpackage

// File: hdl/pppoe_offer_frame_checker_unit.sv
// ---------------------------------------------------------------------------
// PPPoE offer frame checker
// Parses one received Ethernet frame a byte at a time and judges whether it
// is a discovery offer addressed to this station.
// ---------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the s_ stream, one byte per item, with s_tlast on
// the final byte. Every byte updates the header and tag-walk state in the
// cycle it is accepted. The final byte also loads one result item into the
// output register, so the verdict appears on the m_ stream in the cycle after
// the last byte is accepted. All other bytes produce no result.
// Throughput is one byte per cycle; the only limit is the output register.
// While a result waits for m_tready, s_tready is low and every byte of the
// next frame waits too; s_tready follows m_tready in the same cycle, so a
// result taken at once does not stall the input. Bytes past 20 + PAYLOAD_BYTES
// are ignored, but their last flag still closes the frame.
// The APB port holds the station MAC (address 0) and the expected host-uniq
// value (address 8); write it only while no frame is in progress.
// Reset clears both registers, all per-frame state and the output valid flag.
// ---------------------------------------------------------------------------
module pppoe_offer_frame_checker_unit #(
    parameter int unsigned PAYLOAD_BYTES = 1500
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // frame byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [0] accepted, [4:1] verdict, [52:5] sender_mac
);
    import pofc_pkg::*;

    localparam int unsigned FRAME_LIMIT = HEAD_BYTES + PAYLOAD_BYTES;
    localparam int unsigned POS_W       = $clog2(FRAME_LIMIT + 1);
    localparam int unsigned MAX_DECL    = PAYLOAD_BYTES - TAG_SLACK;

    // Configuration registers.
    logic [47:0] own_mac_reg;
    logic [31:0] host_uniq_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg   <= '0;
            host_uniq_reg <= '0;
        end
        else if (cfg_write && paddr[2:0] == 3'd0)
        begin
            if (paddr[3] == REG_OWN_MAC)
            begin
                own_mac_reg <= pwdata[47:0];
            end
            else
            begin
                host_uniq_reg <= pwdata[31:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2:0] == 3'd0)
        begin
            if (paddr[3] == REG_OWN_MAC)
            begin
                prdata = {16'd0, own_mac_reg};
            end
            else
            begin
                prdata = {32'd0, host_uniq_reg};
            end
        end
    end

    // Per-frame state.
    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic             dest_matches_reg, dest_matches_next;
    logic [47:0]      source_address_reg, source_address_next;
    logic [15:0]      frame_ethertype_reg, frame_ethertype_next;
    logic             header_valid_reg, header_valid_next;
    logic [7:0]       frame_code_reg, frame_code_next;
    logic [15:0]      declared_length_reg, declared_length_next;
    logic [POS_W-1:0] tag_start_reg, tag_start_next;
    logic [15:0]      tag_kind_reg, tag_kind_next;
    logic [15:0]      tag_size_reg, tag_size_next;
    logic             walk_active_reg, walk_active_next;
    logic             uniq_comparing_reg, uniq_comparing_next;
    logic             uniq_matched_reg, uniq_matched_next;
    logic             acname_seen_reg, acname_seen_next;
    logic             service_empty_reg, service_empty_next;
    logic             error_seen_reg, error_seen_next;

    logic             out_valid_reg;
    logic [55:0]      out_data_reg;

    logic             in_fire;
    logic [POS_W-1:0] tag_off;
    logic [1:0]       hdr_idx;
    logic [1:0]       uniq_idx;
    logic [16:0]      tag_end;
    verdict_t         verdict;

    assign s_tready = ~out_valid_reg | m_tready;
    assign in_fire  = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign tag_off  = byte_position_reg - POS_W'(HEAD_BYTES);
    assign hdr_idx  = 2'(tag_off - tag_start_reg);
    assign uniq_idx = 2'(tag_off) - 2'(tag_start_reg) + 2'(tag_size_reg);

    always_comb
    begin
        byte_position_next   = byte_position_reg;
        dest_matches_next    = dest_matches_reg;
        source_address_next  = source_address_reg;
        frame_ethertype_next = frame_ethertype_reg;
        header_valid_next    = header_valid_reg;
        frame_code_next      = frame_code_reg;
        declared_length_next = declared_length_reg;
        tag_start_next       = tag_start_reg;
        tag_kind_next        = tag_kind_reg;
        tag_size_next        = tag_size_reg;
        walk_active_next     = walk_active_reg;
        uniq_comparing_next  = uniq_comparing_reg;
        uniq_matched_next    = uniq_matched_reg;
        acname_seen_next     = acname_seen_reg;
        service_empty_next   = service_empty_reg;
        error_seen_next      = error_seen_reg;
        tag_end              = '0;

        if (byte_position_reg < POS_W'(FRAME_LIMIT))
        begin
            byte_position_next = byte_position_reg + 1'b1;
            if (byte_position_reg < POS_W'(6))
            begin
                if (s_tdata != own_mac_reg[8 * (5 - 3'(byte_position_reg)) +: 8])
                begin
                    dest_matches_next = 1'b0;
                end
            end
            else if (byte_position_reg < POS_W'(12))
            begin
                source_address_next = {source_address_reg[39:0], s_tdata};
            end
            else if (byte_position_reg < POS_W'(14))
            begin
                frame_ethertype_next = {frame_ethertype_reg[7:0], s_tdata};
            end
            else if (byte_position_reg == POS_W'(14))
            begin
                header_valid_next = (s_tdata == VER_TYPE_1_1);
            end
            else if (byte_position_reg == POS_W'(15))
            begin
                frame_code_next = s_tdata;
            end
            else if (byte_position_reg < POS_W'(18))
            begin
                // Session id is not checked.
            end
            else if (byte_position_reg < POS_W'(HEAD_BYTES))
            begin
                declared_length_next = {declared_length_reg[7:0], s_tdata};
                if (byte_position_reg == POS_W'(19) &&
                    declared_length_next > 16'(MAX_DECL))
                begin
                    header_valid_next = 1'b0;
                end
            end
            else if (walk_active_reg && header_valid_reg)
            begin
                if (tag_off < tag_start_reg)
                begin
                    // Body byte of the most recently accepted tag.
                    if (uniq_comparing_reg)
                    begin
                        if (s_tdata != host_uniq_reg[8 * (3 - uniq_idx) +: 8])
                        begin
                            uniq_comparing_next = 1'b0;
                        end
                        else if (uniq_idx == 2'd3)
                        begin
                            uniq_matched_next   = 1'b1;
                            uniq_comparing_next = 1'b0;
                        end
                    end
                end
                else if (16'(tag_start_reg) >= declared_length_reg)
                begin
                    walk_active_next = 1'b0;
                end
                else
                begin
                    case (hdr_idx)
                        2'd0:
                        begin
                            tag_kind_next = {s_tdata, 8'd0};
                        end
                        2'd1:
                        begin
                            tag_kind_next = {tag_kind_reg[15:8], s_tdata};
                        end
                        2'd2:
                        begin
                            tag_size_next = {s_tdata, 8'd0};
                        end
                        default:
                        begin
                            tag_size_next = {tag_size_reg[15:8], s_tdata};
                            tag_end = 17'(tag_start_reg) + 17'd4 + {1'b0, tag_size_next};
                            if (tag_kind_reg == TAG_LIST_END ||
                                tag_end > {1'b0, declared_length_reg})
                            begin
                                walk_active_next = 1'b0;
                            end
                            else
                            begin
                                tag_start_next = POS_W'(tag_end);
                                case (tag_kind_reg)
                                    TAG_CONC_NAME:
                                    begin
                                        acname_seen_next = 1'b1;
                                    end
                                    TAG_SVC_NAME:
                                    begin
                                        service_empty_next = (tag_size_next == 16'd0);
                                    end
                                    TAG_SVC_ERROR, TAG_AC_ERROR, TAG_GEN_ERROR:
                                    begin
                                        error_seen_next = 1'b1;
                                    end
                                    TAG_UNIQ_ID:
                                    begin
                                        uniq_comparing_next = (tag_size_next == HOST_UNIQ_BYTES);
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Verdict from the state as it stands after the final byte.
    always_comb
    begin
        if (frame_ethertype_next != ETHERTYPE_DISCOVERY)
        begin
            verdict = VERDICT_ETHERTYPE;
        end
        else if ({1'b0, declared_length_next} + 17'(HEAD_BYTES) > 17'(byte_position_next))
        begin
            verdict = VERDICT_LENGTH;
        end
        else if (!dest_matches_next)
        begin
            verdict = VERDICT_DEST;
        end
        else if (!uniq_matched_next)
        begin
            verdict = VERDICT_HOSTUNIQ;
        end
        else if (frame_code_next != CODE_OFFER)
        begin
            verdict = VERDICT_CODE;
        end
        else if (source_address_next[40])
        begin
            verdict = VERDICT_MCAST_SRC;
        end
        else if (!acname_seen_next)
        begin
            verdict = VERDICT_ACNAME;
        end
        else if (!service_empty_next)
        begin
            verdict = VERDICT_SERVICE;
        end
        else if (error_seen_next)
        begin
            verdict = VERDICT_ERROR_TAG;
        end
        else
        begin
            verdict = VERDICT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= '0;
            dest_matches_reg    <= 1'b1;
            source_address_reg  <= '0;
            frame_ethertype_reg <= '0;
            header_valid_reg    <= 1'b0;
            frame_code_reg      <= '0;
            declared_length_reg <= '0;
            tag_start_reg       <= '0;
            tag_kind_reg        <= '0;
            tag_size_reg        <= '0;
            walk_active_reg     <= 1'b1;
            uniq_comparing_reg  <= 1'b0;
            uniq_matched_reg    <= 1'b0;
            acname_seen_reg     <= 1'b0;
            service_empty_reg   <= 1'b0;
            error_seen_reg      <= 1'b0;
        end
        else if (in_fire && s_tlast)
        begin
            // Frame done: back to the idle state for the next frame.
            byte_position_reg   <= '0;
            dest_matches_reg    <= 1'b1;
            source_address_reg  <= '0;
            frame_ethertype_reg <= '0;
            header_valid_reg    <= 1'b0;
            frame_code_reg      <= '0;
            declared_length_reg <= '0;
            tag_start_reg       <= '0;
            tag_kind_reg        <= '0;
            tag_size_reg        <= '0;
            walk_active_reg     <= 1'b1;
            uniq_comparing_reg  <= 1'b0;
            uniq_matched_reg    <= 1'b0;
            acname_seen_reg     <= 1'b0;
            service_empty_reg   <= 1'b0;
            error_seen_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            byte_position_reg   <= byte_position_next;
            dest_matches_reg    <= dest_matches_next;
            source_address_reg  <= source_address_next;
            frame_ethertype_reg <= frame_ethertype_next;
            header_valid_reg    <= header_valid_next;
            frame_code_reg      <= frame_code_next;
            declared_length_reg <= declared_length_next;
            tag_start_reg       <= tag_start_next;
            tag_kind_reg        <= tag_kind_next;
            tag_size_reg        <= tag_size_next;
            walk_active_reg     <= walk_active_next;
            uniq_comparing_reg  <= uniq_comparing_next;
            uniq_matched_reg    <= uniq_matched_next;
            acname_seen_reg     <= acname_seen_next;
            service_empty_reg   <= service_empty_next;
            error_seen_reg      <= error_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && s_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && s_tlast)
        begin
            out_data_reg <= {3'd0, source_address_next, verdict, verdict == VERDICT_OK};
        end
    end

    property p_frame_end_clears;
        @(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> (byte_position_reg == '0 && walk_active_reg && m_tvalid);
    endproperty
    a_frame_end_clears: assert property (p_frame_end_clears)
        else $error("frame state not cleared or no result after final byte");

    property p_position_bounded;
        @(posedge clk) disable iff (!rst_n)
        byte_position_reg <= POS_W'(FRAME_LIMIT);
    endproperty
    a_position_bounded: assert property (p_position_bounded)
        else $error("byte position ran past the frame limit");

    property p_tag_start_bounded;
        @(posedge clk) disable iff (!rst_n)
        16'(tag_start_reg) <= declared_length_reg || tag_start_reg == '0;
    endproperty
    a_tag_start_bounded: assert property (p_tag_start_bounded)
        else $error("tag walk moved past the declared length");

    property p_accept_flag;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == VERDICT_OK));
    endproperty
    a_accept_flag: assert property (p_accept_flag)
        else $error("accepted flag disagrees with verdict");

    property p_no_result_midframe;
        @(posedge clk) disable iff (!rst_n)
        (in_fire && !s_tlast && !m_tvalid) |=> !m_tvalid;
    endproperty
    a_no_result_midframe: assert property (p_no_result_midframe)
        else $error("result produced without a final byte");

endmodule
